// File: hdl/regular_polygon_vertex_generator_core_assert.svh
// Assertion macros for the polygon vertex generator.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef REGULAR_POLYGON_VERTEX_GENERATOR_CORE_ASSERT_SVH
`define REGULAR_POLYGON_VERTEX_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define RPVG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPVG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rpvg_pkg.sv
// Shared types, constants and functions of the polygon vertex generator.
// No dependencies.
package rpvg_pkg;

  localparam int COORD_W      = 16;
  localparam int RAD_W        = 15;
  localparam int SIDES_W      = 6;
  localparam int ANG_W        = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int XW           = 34;  // CORDIC x/y datapath, 16 fraction bits plus headroom
  localparam int ZW           = 33;  // CORDIC angle, 2^32 units per turn, signed
  localparam int QW           = 17;  // angle step accumulator, holds one full turn
  localparam int GAIN_W       = 30;
  localparam int PROD_W       = RAD_W + GAIN_W;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam logic [QW-1:0] TURN = 17'h10000;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_LOAD = 4'b0010,
    B_ITER = 4'b0100,
    B_POST = 4'b1000
  } back_state_t;

  // one accepted polygon, with the per-vertex step TURN / n as quotient and remainder
  typedef struct packed {
    logic [SIDES_W-1:0]        n;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          rad;
    logic [ANG_W-1:0]          start;
    logic [QW-1:0]             quo;
    logic [SIDES_W-1:0]        rem;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // clamp a 19-bit signed sum to the signed coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W+2:0] s);
    logic [COORD_W-1:0] v;
    if (!s[COORD_W+2] && (s[COORD_W+1:COORD_W-1] != 3'b000))
      v = {1'b0, {(COORD_W-1){1'b1}}};
    else if (s[COORD_W+2] && (s[COORD_W+1:COORD_W-1] != 3'b111))
      v = {1'b1, {(COORD_W-1){1'b0}}};
    else
      v = s[COORD_W-1:0];
    return v;
  endfunction

endpackage

// File: hdl/rpvg_fifo.sv
// Two-entry job queue between the request front end and the vertex engine.
// Depends on rpvg_pkg.
module rpvg_fifo import rpvg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    pop_job,
  output q_stat_t stat
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_job    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

// File: hdl/rpvg_front.sv
// Request front end: takes a polygon item, drops bad side counts and
// divides one turn by the side count bit-serially. Depends on rpvg_pkg.
module rpvg_front import rpvg_pkg::*; #(
  parameter int MAX_SIDES = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  output logic        push,
  output job_t        push_job,
  input  q_stat_t     q_stat
);

  front_state_t       state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [SIDES_W:0]   trial;
  logic               accept, req_ok;

  assign in_tready = (state_r == F_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign req_ok    = (in_tdata[5:0] >= SIDES_W'(3)) &&
                     (in_tdata[5:0] <= SIDES_W'(MAX_SIDES));
  assign push      = (state_r == F_PUSH) && !q_stat.full;
  assign push_job  = job_r;
  // restoring division: shift in the next dividend bit, subtract when it fits
  assign trial     = {job_r.rem, TURN[cnt_r]};

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && req_ok) begin
          job_nxt.n     = in_tdata[5:0];
          job_nxt.cx    = in_tdata[21:6];
          job_nxt.cy    = in_tdata[37:22];
          job_nxt.rad   = in_tdata[52:38];
          job_nxt.start = in_tdata[68:53];
          job_nxt.quo   = '0;
          job_nxt.rem   = '0;
          cnt_nxt       = 5'(QW - 1);
          state_nxt     = F_DIV;
        end
      end
      F_DIV: begin
        if (trial >= {1'b0, job_r.n}) begin
          job_nxt.rem = SIDES_W'(trial - {1'b0, job_r.n});
          job_nxt.quo = {job_r.quo[QW-2:0], 1'b1};
        end else begin
          job_nxt.rem = trial[SIDES_W-1:0];
          job_nxt.quo = {job_r.quo[QW-2:0], 1'b0};
        end
        if (cnt_r == 5'd0) state_nxt = F_PUSH;
        else               cnt_nxt = cnt_r - 5'd1;
      end
      F_PUSH: begin
        if (!q_stat.full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// File: hdl/rpvg_back.sv
// Vertex engine: walks the n+1 vertices of a queued job, runs an iterative
// CORDIC per vertex and drives the output register. Depends on rpvg_pkg.
module rpvg_back import rpvg_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  q_stat_t             q_stat,
  input  job_t                pop_job,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [COORD_W-1:0]  out_x,
  output logic [COORD_W-1:0]  out_y,
  output logic [SIDES_W-1:0]  out_num,
  output logic                out_tlast
);

  localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int IT_W  = $clog2(NSTEP);

  back_state_t               state_r, state_nxt;
  job_t                      job_r, job_nxt;
  logic [SIDES_W-1:0]        vidx_r, vidx_nxt;
  logic [QW-1:0]             accq_r, accq_nxt;
  logic [SIDES_W-1:0]        accr_r, accr_nxt;
  logic                      flip_r, flip_nxt;
  logic signed [XW-1:0]      x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]      z_r, z_nxt;
  logic [IT_W-1:0]           it_r, it_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic [COORD_W-1:0]        ox_r, ox_nxt, oy_r, oy_nxt;
  logic [SIDES_W-1:0]        onum_r, onum_nxt;
  logic                      olast_r, olast_nxt;

  logic [ANG_W-1:0]          ang, angf;
  logic [PROD_W-1:0]         prod;
  logic signed [XW-1:0]      dx, dy, xf, yf, xrnd, yrnd;
  logic signed [ZW-1:0]      at;
  logic [COORD_W+2:0]        sx, sy;
  logic [SIDES_W:0]          rsum;
  logic                      carry, out_free, is_last;

  assign pop        = (state_r == B_IDLE) && !q_stat.empty;
  assign out_free   = !ovalid_r || out_tready;
  assign is_last    = (vidx_r == job_r.n);
  assign out_tvalid = ovalid_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_num    = onum_r;
  assign out_tlast  = olast_r;

  always_comb begin
    // angle of the current vertex; left half plane is turned by half a turn
    ang  = job_r.start + accq_r[ANG_W-1:0];
    angf = (ang[15] ^ ang[14]) ? (ang ^ 16'h8000) : ang;
    prod = PROD_W'(job_r.rad) * PROD_W'(GAIN_Q30);
    dx   = y_r >>> it_r;
    dy   = x_r >>> it_r;
    at   = {1'b0, atan_lut(5'(it_r))};
    xf   = flip_r ? -x_r : x_r;
    yf   = flip_r ? -y_r : y_r;
    xrnd = xf + XW'(32768);
    yrnd = yf + XW'(32768);
    sx   = {xrnd[XW-1], xrnd[XW-1:16]} + {{3{job_r.cx[COORD_W-1]}}, job_r.cx};
    sy   = {yrnd[XW-1], yrnd[XW-1:16]} + {{3{job_r.cy[COORD_W-1]}}, job_r.cy};
    rsum = {1'b0, accr_r} + {1'b0, job_r.rem};
    carry = (rsum >= {1'b0, job_r.n});
  end

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    vidx_nxt   = vidx_r;
    accq_nxt   = accq_r;
    accr_nxt   = accr_r;
    flip_nxt   = flip_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    it_nxt     = it_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    onum_nxt   = onum_r;
    olast_nxt  = olast_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          job_nxt   = pop_job;
          vidx_nxt  = '0;
          accq_nxt  = '0;
          accr_nxt  = pop_job.n >> 1;
          state_nxt = B_LOAD;
        end
      end
      B_LOAD: begin
        flip_nxt  = ang[15] ^ ang[14];
        z_nxt     = {{(ZW-32){angf[15]}}, angf, 16'h0000};
        x_nxt     = XW'(prod[PROD_W-1:14]);
        y_nxt     = '0;
        it_nxt    = '0;
        state_nxt = B_ITER;
      end
      B_ITER: begin
        if (!z_r[ZW-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        if (it_r == IT_W'(NSTEP - 1)) state_nxt = B_POST;
        else                          it_nxt = it_r + IT_W'(1);
      end
      B_POST: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ox_nxt     = sat_coord(sx);
          oy_nxt     = sat_coord(sy);
          onum_nxt   = vidx_r;
          olast_nxt  = is_last;
          if (is_last) begin
            state_nxt = B_IDLE;
          end else begin
            vidx_nxt  = vidx_r + SIDES_W'(1);
            accr_nxt  = carry ? SIDES_W'(rsum - {1'b0, job_r.n}) : rsum[SIDES_W-1:0];
            accq_nxt  = accq_r + job_r.quo + QW'(carry);
            state_nxt = B_LOAD;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    vidx_r  <= vidx_nxt;
    accq_r  <= accq_nxt;
    accr_r  <= accr_nxt;
    flip_r  <= flip_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    it_r    <= it_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    onum_r  <= onum_nxt;
    olast_r <= olast_nxt;
  end

endmodule

// File: hdl/regular_polygon_vertex_generator_core.sv
// Top level of the regular polygon vertex generator.
// Depends on rpvg_pkg, rpvg_front, rpvg_fifo, rpvg_back and the assertion header.
//
//   channel | dir | ports                    | item
//   --------+-----+--------------------------+----------------------------------
//   in_     | in  | tvalid tready tdata      | one polygon request
//   out_    | out | tvalid tready tdata tlast| one vertex, tlast on closing one
//
// A request is divided in the front end (TURN / side count) and handed off to the
// job queue, then taken by the vertex engine, which for each of its n + 1 vertices
// runs a load step with the radius multiply, the CORDIC iterations and an output
// step. The two-entry queue lets the next request be divided while the engine
// works. Side counts below three or above MAX_SIDES are accepted and dropped.
// Reset is synchronous, active low; a stalled output holds the engine in its
// output step.
module regular_polygon_vertex_generator_core import rpvg_pkg::*; #(
  parameter int MAX_SIDES    = 63,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // side_count[5:0], center_x[21:6], center_y[37:22], circum_radius[52:38],
  // start_rotation[68:53], zero fill [71:69]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // vertex_x[15:0], vertex_y[31:16], vertex_number[37:32], zero fill [39:38]
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  q_stat_t            q_stat;
  job_t               push_job, pop_job;
  logic               q_push, q_pop;
  logic [COORD_W-1:0] vx, vy;
  logic [SIDES_W-1:0] vnum;

  rpvg_front #(.MAX_SIDES(MAX_SIDES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .push     (q_push),
    .push_job (push_job),
    .q_stat   (q_stat)
  );

  rpvg_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .pop_job (pop_job),
    .stat    (q_stat)
  );

  rpvg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_job   (pop_job),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_x     (vx),
    .out_y     (vy),
    .out_num   (vnum),
    .out_tlast (out_tlast)
  );

  assign out_tdata = {2'b00, vnum, vy, vx};

`include "regular_polygon_vertex_generator_core_assert.svh"

  `RPVG_ASSERT_IMP(a_no_overflow, q_push, !q_stat.full, "push into full job queue")
  `RPVG_ASSERT_IMP(a_no_underflow, q_pop, !q_stat.empty, "pop from empty job queue")
  `RPVG_ASSERT_NXT(a_front_free, q_push, in_tready, "front not ready after handing off")
  `RPVG_ASSERT_IMP(a_last_index, out_tvalid && out_tlast, (vnum >= SIDES_W'(3)) && (vnum <= SIDES_W'(MAX_SIDES)), "closing vertex index out of range")

endmodule

// File: sim/tb.sv
// Testbench for regular_polygon_vertex_generator_core: polygon requests in, vertices out.
// Vertices are checked against an in-bench CORDIC predictor, or the center at zero radius.
// A directed table comes first. Depends on rpvg_pkg and the core RTL.
module tb import rpvg_pkg::*; ();

  localparam int     MAX_N       = 63;
  localparam int     CORDIC_ITER = 16;
  localparam int     N_RANDOM    = 248;
  localparam int     RUN_LIMIT   = 3000000;
  localparam int     DRAIN_CYC   = 1200;
  localparam longint INV_GAIN    = 64'sd652032874;  // 1/K in Q1.30

  typedef struct packed {
    logic [SIDES_W-1:0]        sides;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          radius;
    logic [ANG_W-1:0]          rot;
  } poly_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic [SIDES_W-1:0]        idx;
    logic                      last;
  } vertex_t;

  // how a directed row gets its expected vertices
  typedef enum logic [1:0] {
    EXP_CALC,       // from the predictor
    EXP_AT_CENTER,  // zero radius: every vertex sits on the center
    EXP_DROPPED     // too few sides: nothing comes out
  } row_kind_t;

  typedef struct packed {
    poly_req_t req;
    row_kind_t kind;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  int      err_cnt      = 0;
  int      cycle_cnt    = 0;
  int      tx_idle_pct  = 0;
  int      rx_stall_pct = 0;
  vertex_t vertex_q[$];

  // arctangent of 2^-i, 2^32 units per turn
  logic [31:0] atan_q32 [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // sides, cx, cy, radius, rotation
  dir_row_t dir_tab [19] = '{
    '{'{6'd0,  16'h0000, 16'h0000, 15'h1000, 16'h0000}, EXP_DROPPED},
    '{'{6'd1,  16'h1000, 16'hF000, 15'h0800, 16'h4000}, EXP_DROPPED},
    '{'{6'd2,  16'h7FFF, 16'h8000, 15'h7FFF, 16'hFFFF}, EXP_DROPPED},
    '{'{6'd4,  16'h03E8, 16'hFC18, 15'h0000, 16'h1234}, EXP_AT_CENTER},
    '{'{6'd63, 16'h7FFF, 16'h8000, 15'h0000, 16'hFFFF}, EXP_AT_CENTER},
    '{'{6'd3,  16'h0000, 16'h0000, 15'h0000, 16'h8000}, EXP_AT_CENTER},
    '{'{6'd3,  16'h0000, 16'h0000, 15'h1000, 16'h0000}, EXP_CALC},
    '{'{6'd3,  16'h7FFF, 16'h7FFF, 15'h7FFF, 16'h0000}, EXP_CALC},
    '{'{6'd4,  16'h8000, 16'h8000, 15'h7FFF, 16'h8000}, EXP_CALC},
    '{'{6'd6,  16'h0000, 16'h0000, 15'h7FFF, 16'hFFFF}, EXP_CALC},
    '{'{6'd63, 16'h0000, 16'h0000, 15'h1000, 16'h0000}, EXP_CALC},
    '{'{6'd5,  16'h0100, 16'hFF00, 15'h2000, 16'h4000}, EXP_CALC},
    '{'{6'd7,  16'hC000, 16'h4000, 15'h3000, 16'hC000}, EXP_CALC},
    '{'{6'd8,  16'h2000, 16'hE000, 15'h4000, 16'h2000}, EXP_CALC},
    '{'{6'd62, 16'h0001, 16'hFFFF, 15'h0001, 16'h1234}, EXP_CALC},
    '{'{6'd32, 16'h7FFF, 16'h8000, 15'h2000, 16'h0000}, EXP_CALC},
    '{'{6'd3,  16'h0000, 16'h0000, 15'h5555, 16'h7FFF}, EXP_CALC},
    '{'{6'd9,  16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hAAAA}, EXP_CALC},
    '{'{6'd10, 16'h5555, 16'hAAAA, 15'h2AAA, 16'h5555}, EXP_CALC}
  };

  regular_polygon_vertex_generator_core #(
    .MAX_SIDES   (MAX_N),
    .CORDIC_STEPS(CORDIC_ITER)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // radius * (cos, sin) of a binary angle, rounded to integers
  function automatic void scaled_cos_sin(input logic [RAD_W-1:0] r, input logic [ANG_W-1:0] ang,
                                         output longint dx, output longint dy);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, sx, sy;
    a    = {ang, 16'h0000};
    flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    // left half plane: rotate by half a turn, negate afterwards
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = (longint'(r) * INV_GAIN) >>> 14;
    y = 0;
    for (int i = 0; i < CORDIC_ITER && i < 24; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (z >= 0) begin
        x = x - sx;
        y = y + sy;
        z = z - longint'(atan_q32[i]);
      end else begin
        x = x + sx;
        y = y - sy;
        z = z + longint'(atan_q32[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    dx = (x + 32768) >>> 16;
    dy = (y + 32768) >>> 16;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic void queue_polygon(input poly_req_t r);
    int               n, stepv;
    longint           dx, dy;
    logic [ANG_W-1:0] ang;
    vertex_t          v;
    n = int'(r.sides);
    if (n < 3 || n > MAX_N) return;
    for (int i = 0; i <= n; i++) begin
      stepv = (i * 65536 + n / 2) / n;
      ang   = r.rot + stepv[15:0];
      scaled_cos_sin(r.radius, ang, dx, dy);
      v.vx   = clamp_coord(longint'($signed(r.cx)) + dx);
      v.vy   = clamp_coord(longint'($signed(r.cy)) + dy);
      v.idx  = 6'(i);
      v.last = (i == n);
      vertex_q.push_back(v);
    end
  endfunction

  function automatic poly_req_t random_request();
    poly_req_t r;
    int        pick;
    pick = int'($urandom_range(99));
    if (pick < 8)
      r.sides = 6'($urandom_range(2));
    else if (pick < 85)
      r.sides = 6'($urandom_range(12, 3));
    else
      r.sides = 6'($urandom_range(63, 13));
    r.cx     = 16'($urandom);
    r.cy     = 16'($urandom);
    r.radius = ($urandom_range(1) == 0) ? 15'($urandom) : 15'($urandom_range(4096));
    r.rot    = 16'($urandom);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_request(input poly_req_t r, input row_kind_t kind);
    vertex_t v;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, r.rot, r.radius, r.cy, r.cx, r.sides};
    do @(posedge clk); while (!in_tready);
    case (kind)
      EXP_CALC: queue_polygon(r);
      EXP_AT_CENTER: begin
        for (int i = 0; i <= int'(r.sides); i++) begin
          v.vx   = r.cx;
          v.vy   = r.cy;
          v.idx  = 6'(i);
          v.last = (i == int'(r.sides));
          vertex_q.push_back(v);
        end
      end
      default: ;
    endcase
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (vertex_q.size() != 0);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin : vertex_check
    vertex_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (vertex_q.size() == 0) begin
        flag_mismatch("unexpected vertex, number", longint'(out_tdata[37:32]), -1);
      end else begin
        want = vertex_q.pop_front();
        if (out_tdata[15:0] != want.vx)
          flag_mismatch("vertex_x", longint'($signed(out_tdata[15:0])), longint'(want.vx));
        if (out_tdata[31:16] != want.vy)
          flag_mismatch("vertex_y", longint'($signed(out_tdata[31:16])), longint'(want.vy));
        if (out_tdata[37:32] != want.idx)
          flag_mismatch("vertex_number", longint'(out_tdata[37:32]), longint'(want.idx));
        if (out_tlast != want.last)
          flag_mismatch("last_vertex", longint'(out_tlast), longint'(want.last));
      end
    end
  end

  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[k]) send_request(dir_tab[k].req, dir_tab[k].kind);
    hold_until_drained();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
      endcase
      for (int k = 0; k < N_RANDOM / 4; k++) send_request(random_request(), EXP_CALC);
    end
    hold_until_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
